/* rtl/amtp_pkg.sv */
// ----------------------------------------------------------------------------
// amtp_pkg
// Shared constants for the audio mix tone picker: register indexes, reset
// values and the fixed widths of the tone arithmetic.
// ----------------------------------------------------------------------------
package amtp_pkg;

   // Configuration register indexes
   localparam logic [2:0] REG_SILENCE_LEVEL  = 3'd0;
   localparam logic [2:0] REG_MIN_TONE_HZ    = 3'd1;
   localparam logic [2:0] REG_MAX_TONE_HZ    = 3'd2;
   localparam logic [2:0] REG_SAMPLE_RATE_HZ = 3'd3;
   localparam logic [2:0] REG_BASS_HOLD      = 3'd4;
   localparam logic [2:0] REG_MELODY_HOLD    = 3'd5;
   localparam logic [2:0] REG_FALLBACK_HOLD  = 3'd6;

   // Register reset values
   localparam logic [15:0] RST_SILENCE_LEVEL  = 16'd256;
   localparam logic [15:0] RST_MIN_TONE_HZ    = 16'd40;
   localparam logic [15:0] RST_MAX_TONE_HZ    = 16'd12000;
   localparam logic [17:0] RST_SAMPLE_RATE_HZ = 18'd44100;
   localparam logic [7:0]  RST_BASS_HOLD      = 8'd6;
   localparam logic [7:0]  RST_MELODY_HOLD    = 8'd5;
   localparam logic [7:0]  RST_FALLBACK_HOLD  = 8'd8;

   // Quotient width of the voice and estimate divisions
   localparam int QW = 18;
   // Voice frequency numerator, 131072
   localparam logic [QW-1:0] VOICE_NUM = 18'h20000;
   // Period base, 2048
   localparam logic [11:0] PERIOD_BASE = 12'h800;

   // Register snapshot bits
   localparam int MS_POWER_BIT = 7;
   localparam logic [7:0] ENV_VOLUME_MASK = 8'hF0;
   localparam int DAC_ON_BIT = 7;
   localparam logic [7:0] WAVE_LEVEL_MASK = 8'h60;

   // Voice indexes
   localparam logic [1:0] VOICE_SQ1  = 2'd0;
   localparam logic [1:0] VOICE_SQ2  = 2'd1;
   localparam logic [1:0] VOICE_WAVE = 2'd2;

endpackage

/* rtl/audio_mix_to_tone_picker.sv */
// ----------------------------------------------------------------------------
// audio_mix_to_tone_picker
// Picks one or two speaker tones per frame from a PCM mix and a snapshot of
// sound-chip voice registers.
// ----------------------------------------------------------------------------
// Usage:
//  - req_ channel: an item is taken when req_valid is high and req_stall low.
//    A sample item (req_action 0) updates the frame totals and yields
//    nothing; the next item may follow at once.
//  - A frame-end item (req_action 1) latches the totals and snapshot, clears
//    the totals and starts a sequencer over one shift-add adder and one
//    restoring divider: two multiplies, then COUNT_WIDTH + 18 divide
//    steps for the crossing estimate and 3 x 18 for the voice periods.
//    A silent frame skips the rest after the first multiply.
//    The divider yields one quotient bit a cycle.
//  - req_stall stays high from the frame end until every tone is taken.
//  - rsp_ channel: one or two tones, held in an output register while
//    rsp_stall is high; rsp_last_tone marks the final tone of the frame.
//  - csr_ channel: always ready; user writes only while the block is idle; unenforced.
//  - reset (synchronous) clears totals, sign history, arpeggio phase and
//    loads the register defaults.
// ----------------------------------------------------------------------------
module audio_mix_to_tone_picker #(
   parameter int COUNT_WIDTH  = 32,
   parameter int ENERGY_WIDTH = 48
) (
   input  logic               clock,
   input  logic               reset,
   // input items
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_action,
   input  logic signed [15:0] req_left_sample,
   input  logic signed [15:0] req_right_sample,
   input  logic [7:0]         req_master_status,
   input  logic [7:0]         req_square1_envelope,
   input  logic [10:0]        req_square1_period,
   input  logic [7:0]         req_square2_envelope,
   input  logic [10:0]        req_square2_period,
   input  logic [7:0]         req_wave_dac_control,
   input  logic [7:0]         req_wave_level_code,
   input  logic [10:0]        req_wave_period,
   // result items
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [15:0]        rsp_tone_hz,
   output logic [7:0]         rsp_hold_ms,
   output logic               rsp_last_tone,
   // configuration writes
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [17:0]        csr_data
);

   localparam int CW  = COUNT_WIDTH;
   localparam int EW  = ENERGY_WIDTH;
   localparam int QW  = amtp_pkg::QW;
   localparam int PW  = CW + QW;
   localparam int CMW = (PW > EW) ? PW : EW;
   localparam int SW  = $clog2(PW + 1);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_MULS = 3'd1;
   localparam logic [2:0] S_CHK  = 3'd2;
   localparam logic [2:0] S_MULR = 3'd3;
   localparam logic [2:0] S_DIVE = 3'd4;
   localparam logic [2:0] S_DIVV = 3'd5;
   localparam logic [2:0] S_EMIT = 3'd6;
   localparam logic [2:0] S_WAIT = 3'd7;

   localparam logic [SW-1:0] LAST_SIL  = SW'(15);
   localparam logic [SW-1:0] LAST_RATE = SW'(QW - 1);
   localparam logic [SW-1:0] LAST_EST  = SW'(PW - 1);
   localparam logic [SW-1:0] LAST_VOX  = SW'(QW - 1);

   // configuration registers
   logic [15:0] silence_ff, min_hz_ff, max_hz_ff;
   logic [17:0] rate_ff;
   logic [7:0]  bass_ms_ff, mel_ms_ff, fb_ms_ff;

   // frame totals and history
   logic [CW-1:0] cross_ff, cross_in, nsamp_ff, nsamp_in;
   logic [EW-1:0] energy_ff, energy_in;
   logic          prev_neg_ff, prev_neg_in, have_prev_ff, have_prev_in;
   logic          phase_ff, phase_in;

   // latched frame
   logic [CW-1:0] n_ff, n_in, zc_ff, zc_in;
   logic [EW-1:0] e_ff, e_in;
   logic [7:0]    ms_ff, ms_in;
   logic          env1_ff, env1_in, env2_ff, env2_in, wav_ff, wav_in;
   logic [10:0]   p1_ff, p1_in, p2_ff, p2_in, pw_ff, pw_in;

   // sequencer and shared arithmetic
   logic [2:0]    state_ff, state_in;
   logic [SW-1:0] step_ff, step_in;
   logic [1:0]    voice_ff, voice_in;
   logic [PW-1:0] acc_ff, acc_in, acc_step;
   logic [CW-1:0] mcand_ff, mcand_in;
   logic [QW-1:0] mplier_ff, mplier_in;
   logic [PW-1:0] dvd_ff, dvd_in;
   logic [CW:0]   rem_ff, rem_in, rem_sh, rem_step;
   logic [CW-1:0] dsr_ff, dsr_in;
   logic [QW-1:0] q_ff, q_in, q_step;
   logic          qov_ff, qov_in, qov_step;
   logic          div_ge;

   // frame results
   logic          aud_ff, aud_in;
   logic [QW-2:0] est_ff, est_in;
   logic          est_ov_ff, est_ov_in;
   logic [QW-1:0] f1_ff, f1_in, f2_ff, f2_in, fw_ff, fw_in;

   // output register and second tone
   logic          rsp_valid_ff, rsp_valid_in;
   logic [15:0]   tone_ff, tone_in, tone2_ff, tone2_in;
   logic [7:0]    hold_ff, hold_in, hold2_ff, hold2_in;
   logic          last_ff, last_in, have2_ff, have2_in;

   // sample datapath
   logic [16:0]   mono, mag;
   logic [EW:0]   esum;
   logic          in_take;

   // emit decisions
   logic          a1, a2, aw, mel, est_ok;
   logic [QW-1:0] fmel;

   assign req_stall     = (state_ff != S_IDLE);
   assign csr_ready     = 1'b1;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_tone_hz   = tone_ff;
   assign rsp_hold_ms   = hold_ff;
   assign rsp_last_tone = last_ff;
   assign in_take       = req_valid && !req_stall;

   function automatic logic [11:0] period_div(input logic [10:0] p);
      period_div = amtp_pkg::PERIOD_BASE - {1'b0, p};
   endfunction

   function automatic logic in_rng(input logic [QW-1:0] f, input logic [15:0] lo,
                                   input logic [15:0] hi);
      in_rng = (f >= QW'(lo)) && (f <= QW'(hi));
   endfunction

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         silence_ff <= amtp_pkg::RST_SILENCE_LEVEL;
         min_hz_ff  <= amtp_pkg::RST_MIN_TONE_HZ;
         max_hz_ff  <= amtp_pkg::RST_MAX_TONE_HZ;
         rate_ff    <= amtp_pkg::RST_SAMPLE_RATE_HZ;
         bass_ms_ff <= amtp_pkg::RST_BASS_HOLD;
         mel_ms_ff  <= amtp_pkg::RST_MELODY_HOLD;
         fb_ms_ff   <= amtp_pkg::RST_FALLBACK_HOLD;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            amtp_pkg::REG_SILENCE_LEVEL:  silence_ff <= csr_data[15:0];
            amtp_pkg::REG_MIN_TONE_HZ:    min_hz_ff  <= csr_data[15:0];
            amtp_pkg::REG_MAX_TONE_HZ:    max_hz_ff  <= csr_data[15:0];
            amtp_pkg::REG_SAMPLE_RATE_HZ: rate_ff    <= csr_data;
            amtp_pkg::REG_BASS_HOLD:      bass_ms_ff <= csr_data[7:0];
            amtp_pkg::REG_MELODY_HOLD:    mel_ms_ff  <= csr_data[7:0];
            amtp_pkg::REG_FALLBACK_HOLD:  fb_ms_ff   <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   // mono mix, magnitude and saturating energy sum
   always_comb begin
      mono = {req_left_sample[15], req_left_sample[15], req_left_sample[15:1]}
           + {req_right_sample[15], req_right_sample[15], req_right_sample[15:1]};
      mag  = mono[16] ? (17'd0 - mono) : mono;
      esum = {1'b0, energy_ff} + (EW+1)'(mag);
   end

   // shared adder step and divider step
   always_comb begin
      acc_step = {acc_ff[PW-2:0], 1'b0} + (mplier_ff[QW-1] ? PW'(mcand_ff) : '0);
      rem_sh   = {rem_ff[CW-1:0], dvd_ff[PW-1]};
      div_ge   = (rem_sh >= {1'b0, dsr_ff});
      rem_step = div_ge ? (rem_sh - {1'b0, dsr_ff}) : rem_sh;
      q_step   = {q_ff[QW-2:0], div_ge};
      qov_step = qov_ff | q_ff[QW-1];
   end

   // voice audibility and tone choice
   always_comb begin
      a1  = ms_ff[amtp_pkg::MS_POWER_BIT] && ms_ff[0] && env1_ff
            && in_rng(f1_ff, min_hz_ff, max_hz_ff);
      a2  = ms_ff[amtp_pkg::MS_POWER_BIT] && ms_ff[1] && env2_ff
            && in_rng(f2_ff, min_hz_ff, max_hz_ff);
      aw  = ms_ff[amtp_pkg::MS_POWER_BIT] && ms_ff[2] && wav_ff
            && in_rng(fw_ff, min_hz_ff, max_hz_ff);
      mel = a1 || a2;
      if (a1 && a2) fmel = phase_ff ? f2_ff : f1_ff;
      else          fmel = a1 ? f1_ff : f2_ff;
      est_ok = !est_ov_ff && in_rng({1'b0, est_ff}, min_hz_ff, max_hz_ff);
   end

   // sequencer
   always_comb begin
      state_in = state_ff;  step_in = step_ff;  voice_in = voice_ff;
      cross_in = cross_ff;  nsamp_in = nsamp_ff;  energy_in = energy_ff;
      prev_neg_in = prev_neg_ff;  have_prev_in = have_prev_ff;  phase_in = phase_ff;
      n_in = n_ff;  zc_in = zc_ff;  e_in = e_ff;  ms_in = ms_ff;
      env1_in = env1_ff;  env2_in = env2_ff;  wav_in = wav_ff;
      p1_in = p1_ff;  p2_in = p2_ff;  pw_in = pw_ff;
      acc_in = acc_ff;  mcand_in = mcand_ff;  mplier_in = mplier_ff;
      dvd_in = dvd_ff;  rem_in = rem_ff;  dsr_in = dsr_ff;
      q_in = q_ff;  qov_in = qov_ff;
      aud_in = aud_ff;  est_in = est_ff;  est_ov_in = est_ov_ff;
      f1_in = f1_ff;  f2_in = f2_ff;  fw_in = fw_ff;
      rsp_valid_in = rsp_valid_ff;  tone_in = tone_ff;  hold_in = hold_ff;
      last_in = last_ff;  tone2_in = tone2_ff;  hold2_in = hold2_ff;
      have2_in = have2_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (in_take && !req_action) begin
               // sample item
               if (mono != 17'd0) begin
                  if (have_prev_ff && (mono[16] != prev_neg_ff) && (cross_ff != '1))
                     cross_in = cross_ff + CW'(1);
                  prev_neg_in  = mono[16];
                  have_prev_in = 1'b1;
               end
               energy_in = esum[EW] ? '1 : esum[EW-1:0];
               if (nsamp_ff != '1) nsamp_in = nsamp_ff + CW'(1);
            end else if (in_take) begin
               // frame end: latch and clear totals
               n_in = nsamp_ff;  zc_in = cross_ff;  e_in = energy_ff;
               cross_in = '0;  nsamp_in = '0;  energy_in = '0;
               ms_in   = req_master_status;
               env1_in = (req_square1_envelope & amtp_pkg::ENV_VOLUME_MASK) != 8'd0;
               env2_in = (req_square2_envelope & amtp_pkg::ENV_VOLUME_MASK) != 8'd0;
               wav_in  = req_wave_dac_control[amtp_pkg::DAC_ON_BIT]
                         && ((req_wave_level_code & amtp_pkg::WAVE_LEVEL_MASK) != 8'd0);
               p1_in = req_square1_period;  p2_in = req_square2_period;
               pw_in = req_wave_period;
               acc_in = '0;  mcand_in = nsamp_ff;  mplier_in = {silence_ff, 2'b00};
               step_in = '0;
               state_in = S_MULS;
            end
         end
         S_MULS: begin
            // silence_level * n, MSB first
            acc_in = acc_step;  mplier_in = {mplier_ff[QW-2:0], 1'b0};
            step_in = step_ff + SW'(1);
            if (step_ff == LAST_SIL) state_in = S_CHK;
         end
         S_CHK: begin
            aud_in = (n_ff != '0) && (CMW'(e_ff) >= CMW'(acc_ff));
            acc_in = '0;  mcand_in = zc_ff;  mplier_in = rate_ff;  step_in = '0;
            state_in = aud_in ? S_MULR : S_EMIT;
         end
         S_MULR: begin
            // crossings * sample rate
            acc_in = acc_step;  mplier_in = {mplier_ff[QW-2:0], 1'b0};
            step_in = step_ff + SW'(1);
            if (step_ff == LAST_RATE) begin
               dvd_in = acc_step;  rem_in = '0;  dsr_in = n_ff;
               q_in = '0;  qov_in = 1'b0;  step_in = '0;
               state_in = S_DIVE;
            end
         end
         S_DIVE: begin
            // (crossings * rate) / n, quotient kept narrow with overflow flag
            dvd_in = {dvd_ff[PW-2:0], 1'b0};  rem_in = rem_step;
            q_in = q_step;  qov_in = qov_step;  step_in = step_ff + SW'(1);
            if (step_ff == LAST_EST) begin
               est_in = q_step[QW-1:1];  est_ov_in = qov_step;
               dvd_in = {amtp_pkg::VOICE_NUM, CW'(0)};  rem_in = '0;
               dsr_in = CW'(period_div(p1_ff));  q_in = '0;  qov_in = 1'b0;
               step_in = '0;  voice_in = amtp_pkg::VOICE_SQ1;
               state_in = S_DIVV;
            end
         end
         S_DIVV: begin
            // 131072 / (2048 - period) for each voice
            dvd_in = {dvd_ff[PW-2:0], 1'b0};  rem_in = rem_step;
            q_in = q_step;  qov_in = qov_step;  step_in = step_ff + SW'(1);
            if (step_ff == LAST_VOX) begin
               dvd_in = {amtp_pkg::VOICE_NUM, CW'(0)};  rem_in = '0;
               q_in = '0;  qov_in = 1'b0;  step_in = '0;
               unique case (voice_ff)
                  amtp_pkg::VOICE_SQ1: begin
                     f1_in = q_step;  voice_in = amtp_pkg::VOICE_SQ2;
                     dsr_in = CW'(period_div(p2_ff));
                  end
                  amtp_pkg::VOICE_SQ2: begin
                     f2_in = q_step;  voice_in = amtp_pkg::VOICE_WAVE;
                     dsr_in = CW'(period_div(pw_ff));
                  end
                  default: begin
                     fw_in = q_step;  state_in = S_EMIT;
                  end
               endcase
            end
         end
         S_EMIT: begin
            rsp_valid_in = 1'b1;  last_in = 1'b1;  have2_in = 1'b0;
            tone_in = '0;  hold_in = '0;
            if (!aud_ff) begin
               // silent frame
            end else if (!mel && !aw) begin
               if (est_ok) begin
                  tone_in = est_ff[15:0];  hold_in = fb_ms_ff;
               end
            end else if (aw) begin
               tone_in = fw_ff[15:0];  hold_in = bass_ms_ff;  last_in = !mel;
               have2_in = mel;  tone2_in = fmel[15:0];  hold2_in = mel_ms_ff;
               if (mel) phase_in = !phase_ff;
            end else begin
               tone_in = fmel[15:0];  hold_in = mel_ms_ff;
               phase_in = !phase_ff;
            end
            state_in = S_WAIT;
         end
         S_WAIT: begin
            if (rsp_valid_ff && !rsp_stall) begin
               if (have2_ff) begin
                  tone_in = tone2_ff;  hold_in = hold2_ff;
                  last_in = 1'b1;  have2_in = 1'b0;
               end else begin
                  rsp_valid_in = 1'b0;
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= '0;
         voice_ff     <= amtp_pkg::VOICE_SQ1;
         cross_ff     <= '0;
         nsamp_ff     <= '0;
         energy_ff    <= '0;
         prev_neg_ff  <= 1'b0;
         have_prev_ff <= 1'b0;
         phase_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         have2_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         voice_ff     <= voice_in;
         cross_ff     <= cross_in;
         nsamp_ff     <= nsamp_in;
         energy_ff    <= energy_in;
         prev_neg_ff  <= prev_neg_in;
         have_prev_ff <= have_prev_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
         have2_ff     <= have2_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      n_ff <= n_in;  zc_ff <= zc_in;  e_ff <= e_in;  ms_ff <= ms_in;
      env1_ff <= env1_in;  env2_ff <= env2_in;  wav_ff <= wav_in;
      p1_ff <= p1_in;  p2_ff <= p2_in;  pw_ff <= pw_in;
      acc_ff <= acc_in;  mcand_ff <= mcand_in;  mplier_ff <= mplier_in;
      dvd_ff <= dvd_in;  rem_ff <= rem_in;  dsr_ff <= dsr_in;
      q_ff <= q_in;  qov_ff <= qov_in;
      aud_ff <= aud_in;  est_ff <= est_in;  est_ov_ff <= est_ov_in;
      f1_ff <= f1_in;  f2_ff <= f2_in;  fw_ff <= fw_in;
      tone_ff <= tone_in;  hold_ff <= hold_in;  last_ff <= last_in;
      tone2_ff <= tone2_in;  hold2_ff <= hold2_in;
   end

   // checks
   a_valid_in_wait: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (state_ff == S_WAIT))
      else $error("tone shown outside the wait state");

   a_pending_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && have2_ff) |-> !rsp_last_tone)
      else $error("last tone flagged with a second tone pending");

   a_frame_totals_clear: assert property (@(posedge clock) disable iff (reset)
      (in_take && req_action) |=> (nsamp_ff == '0) && (cross_ff == '0))
      else $error("frame end did not clear the totals");

endmodule
